// ----- rtl/core/skvt_pkg.sv -----
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared constants and types for the small key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic issue;
    logic load;
  } skvt_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic quick;
    logic more;
    logic done;
  } skvt_sts_t;

endpackage

// ----- rtl/core/skvt_ifs.sv -----
// ----------------------------------------------------------------------------
// skvt interfaces
// Request and response channels of the small key/value table.
// ----------------------------------------------------------------------------
interface skvt_req_if
  import skvt_pkg::*;
#(
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             command;
  logic signed [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0]        value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface skvt_rsp_if
  import skvt_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [VALUE_BITS-1:0] found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

// ----- rtl/core/skvt_datapath.sv -----
// ----------------------------------------------------------------------------
// skvt_datapath
// Slot memory, scan address and compare stage, result and output registers.
// ----------------------------------------------------------------------------
module skvt_datapath
  import skvt_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  skvt_ctl_t                  ctl,
  output skvt_sts_t                  sts,
  input  logic [CMD_W-1:0]           req_command,
  input  logic signed [KEY_BITS-1:0] req_key,
  input  logic [VALUE_BITS-1:0]      req_value,
  output logic [STATUS_W-1:0]        rsp_status,
  output logic [VALUE_BITS-1:0]      rsp_found_value
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int LAST  = ENTRIES - 1;

  logic [CMD_W-1:0]           command;
  logic [KEY_BITS-1:0]        key;
  logic [VALUE_BITS-1:0]      value;
  logic [CNT_W-1:0]           rd_cnt;
  logic                       cmp_live;
  logic [IDX_W-1:0]           cmp_idx;
  logic [KEY_BITS-1:0]        rd_key;
  logic [VALUE_BITS-1:0]      rd_value;
  logic                       rd_vld;
  logic [ENTRIES-1:0]         slot_vld;
  logic [STATUS_W-1:0]        res_status;
  logic [VALUE_BITS-1:0]      res_value;

  logic [KEY_BITS-1:0]        key_mem   [ENTRIES];
  logic [VALUE_BITS-1:0]      value_mem [ENTRIES];

  logic                       req_clear;
  logic                       req_bad_key;
  logic                       key_hit;
  logic                       stop;
  logic                       cmp_last;
  logic                       add_write;
  logic                       rem_hit;
  logic [STATUS_W-1:0]        scan_status;
  logic [VALUE_BITS-1:0]      scan_value;

  assign req_clear   = (req_command == CMD_CLEAR);
  assign req_bad_key = req_key[KEY_BITS-1] || (req_key == '0);

  assign sts.quick = req_clear ||
                     (((req_command == CMD_ADD) || (req_command == CMD_REMOVE)) && req_bad_key);
  assign sts.more  = (rd_cnt < CNT_W'(ENTRIES));

  assign key_hit  = rd_vld && (rd_key == key);
  assign cmp_last = (cmp_idx == IDX_W'(LAST));

  always_comb begin
    case (command)
      CMD_ADD:    stop = key_hit || !rd_vld;
      CMD_REMOVE: stop = key_hit;
      CMD_FIND:   stop = key_hit || (!rd_vld && (key == '0));
      default:    stop = 1'b1;
    endcase
  end

  assign sts.done  = cmp_live && (stop || cmp_last);
  assign add_write = cmp_live && (command == CMD_ADD) && !rd_vld;
  assign rem_hit   = cmp_live && (command == CMD_REMOVE) && key_hit;

  always_comb begin
    if (stop) begin
      scan_status = ((command == CMD_ADD) && key_hit) ? ST_EXISTS : ST_OK;
    end else if (command == CMD_ADD) begin
      scan_status = ST_NO_SPACE;
    end else begin
      scan_status = ST_NOT_FOUND;
    end
    scan_value = ((command == CMD_FIND) && stop && rd_vld) ? rd_value : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      command <= req_command;
      key     <= req_key;
      value   <= req_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt   <= '0;
      cmp_live <= 1'b0;
    end else begin
      if (ctl.accept) begin
        rd_cnt <= '0;
      end else if (ctl.issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      cmp_live <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rd_key   <= key_mem[rd_cnt[IDX_W-1:0]];
      rd_value <= value_mem[rd_cnt[IDX_W-1:0]];
      rd_vld   <= slot_vld[rd_cnt[IDX_W-1:0]];
      cmp_idx  <= rd_cnt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (add_write) begin
      key_mem[cmp_idx]   <= key;
      value_mem[cmp_idx] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (ctl.accept && req_clear) begin
      slot_vld <= '0;
    end else if (add_write) begin
      slot_vld[cmp_idx] <= 1'b1;
    end else if (rem_hit) begin
      slot_vld[cmp_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      res_status <= req_clear ? ST_OK : ST_INVALID;
      res_value  <= '0;
    end else if (sts.done) begin
      res_status <= scan_status;
      res_value  <= scan_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rsp_status      <= res_status;
      rsp_found_value <= res_value;
    end
  end

endmodule

// ----- rtl/core/skvt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skvt_ctrl
// Sequencer for the key/value table: accept, slot scan, result hand-off.
// ----------------------------------------------------------------------------
module skvt_ctrl
  import skvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output skvt_ctl_t ctl,
  input  skvt_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready  = (state == S_IDLE);
  assign ctl.accept = req_valid && req_ready;
  assign ctl.issue  = (state == S_SCAN) && sts.more && !sts.done;
  assign ctl.load   = (state == S_POST) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctl.accept) begin
          state_next = sts.quick ? S_POST : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.done) begin
          state_next = S_POST;
        end
      end
      S_POST: begin
        if (ctl.load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/small_key_value_table.sv -----
// ----------------------------------------------------------------------------
// small_key_value_table
// Fixed table of key/value slots with clear, add, remove and find commands.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command with its key and value; rsp returns one status and
//   found_value per request transaction, in order.
//   Clear, and add or remove with a key at or below zero, finish without a
//   scan. Other commands scan the slots from index 0, one slot per cycle
//   through the registered slot memory read port, and stop at the slot that
//   decides the command or after the last slot. A new request can be taken in
//   the cycle after the result is loaded. The result sits in an output
//   register; while rsp is stalled the next request is still taken and
//   scanned, and its result waits until the output register frees up.
//   Reset empties every slot at once through per-slot valid flags; no
//   clearing pass is needed, and requests are taken right after reset.
// ----------------------------------------------------------------------------
module small_key_value_table
  import skvt_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic       clk,
  input logic       rst,
  skvt_req_if.sink  req,
  skvt_rsp_if.source rsp
);

  skvt_ctl_t ctl;
  skvt_sts_t sts;

  skvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  skvt_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .req_command     (req.command),
    .req_key         (req.key),
    .req_value       (req.value),
    .rsp_status      (rsp.status),
    .rsp_found_value (rsp.found_value)
  );

endmodule

// ----- rtl/core/skvt_checker.sv -----
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level checks for the key/value table, bound to the top level.
// ----------------------------------------------------------------------------
module skvt_checker
  import skvt_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [STATUS_W-1:0]   rsp_status,
  input logic [VALUE_BITS-1:0] rsp_found_value
);

  logic       req_acc;
  logic       rsp_acc;
  logic [1:0] pending;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_acc) - 2'(rsp_acc);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found_value))
    else $error("rsp payload changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_INVALID ||
                   rsp_status == ST_EXISTS || rsp_status == ST_NO_SPACE ||
                   rsp_status == ST_NOT_FOUND))
    else $error("undefined status code");

  a_value_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> (rsp_found_value == '0))
    else $error("nonzero found_value on failed command");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_acc |-> (pending != 2'd0))
    else $error("response without outstanding request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    req_acc |-> (pending < 2'd2))
    else $error("request taken with two transactions outstanding");

endmodule

bind small_key_value_table skvt_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_skvt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_found_value (rsp.found_value)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for small_key_value_table. Directed commands cover the
// key extremes, invalid keys, duplicates hidden behind a freed slot, a full
// table and key-zero lookups. Random traffic follows, mostly add, remove and
// find on a small key pool so the table fills and empties, plus noise. A
// scoreboard class keeps its own copy of the slots and checks every response
// transaction in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
import skvt_pkg::*;

localparam int KEY_W   = DEF_KEY_BITS;
localparam int VAL_W   = DEF_VALUE_BITS;
localparam int SLOTS   = DEF_ENTRIES;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    found_value;
} kv_result_t;

class kv_scoreboard;
  logic signed [KEY_W-1:0] slot_key [SLOTS];
  logic [VAL_W-1:0]        slot_val [SLOTS];
  kv_result_t              expected_q [$];
  int unsigned             error_count;
  int unsigned             checked_count;
  int unsigned             cmd_seen [4];
  int unsigned             status_seen [8];

  function new();
    wipe();
    error_count   = 0;
    checked_count = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function void wipe();
    foreach (slot_key[i]) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report_mismatch(string what);
    error_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function void note_request(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] key,
                             logic [VAL_W-1:0] val);
    kv_result_t r;
    bit         hit;
    r.status      = ST_OK;
    r.found_value = '0;
    hit           = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        wipe();
      end
      CMD_ADD: begin
        if (key <= 0) begin
          r.status = ST_INVALID;
        end else begin
          r.status = ST_NO_SPACE;
          for (int i = 0; i < SLOTS; i++) begin
            if (!hit) begin
              if (slot_key[i] == key) begin
                r.status = ST_EXISTS;
                hit      = 1'b1;
              end else if (slot_key[i] == 0) begin
                slot_key[i] = key;
                slot_val[i] = val;
                r.status    = ST_OK;
                hit         = 1'b1;
              end
            end
          end
        end
      end
      CMD_REMOVE: begin
        if (key <= 0) begin
          r.status = ST_INVALID;
        end else begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < SLOTS; i++) begin
            if (!hit && slot_key[i] == key) begin
              slot_key[i] = '0;
              slot_val[i] = '0;
              r.status    = ST_OK;
              hit         = 1'b1;
            end
          end
        end
      end
      default: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && slot_key[i] == key) begin
            r.found_value = slot_val[i];
            r.status      = ST_OK;
            hit           = 1'b1;
          end
        end
      end
    endcase
    cmd_seen[cmd]++;
    status_seen[r.status]++;
    expected_q.push_back(r);
  endfunction

  task check_response(logic [STATUS_W-1:0] status, logic [VAL_W-1:0] found_value);
    kv_result_t e;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected response status=%0d value=%h",
                                status, found_value));
    end else begin
      e = expected_q.pop_front();
      checked_count++;
      if (status !== e.status)
        report_mismatch($sformatf("status got %0d exp %0d", status, e.status));
      if (found_value !== e.found_value)
        report_mismatch($sformatf("found_value got %h exp %h",
                                  found_value, e.found_value));
    end
  endtask
endclass

module tb;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1415;
  localparam int DRAIN_CYCLES = 3 * (SLOTS + 3);

  logic        clk = 1'b0;
  logic        rst;
  int unsigned cycle_count = 0;
  int          burst_left  = 0;
  logic signed [KEY_W-1:0] key_base = 16'sd1;

  int          stall_mode;
  int          mode_left;
  int          pattern_idx;
  logic [7:0]  stall_pattern = 8'b1011_0010;

  kv_scoreboard sb = new();

  skvt_req_if #(.KEY_BITS(KEY_W), .VALUE_BITS(VAL_W)) req_ch ();
  skvt_rsp_if #(.VALUE_BITS(VAL_W))                   rsp_ch ();

  small_key_value_table #(
    .ENTRIES(SLOTS), .KEY_BITS(KEY_W), .VALUE_BITS(VAL_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response stalls: always ready, random, or a fixed rotating pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_mode   <= 0;
      mode_left    <= 0;
      pattern_idx  <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(32, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= ($urandom_range(0, 99) < 65);
        default: rsp_ch.ready <= stall_pattern[pattern_idx];
      endcase
      pattern_idx <= (pattern_idx + 1) % 8;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.status, rsp_ch.found_value);
  end

  task automatic drive_item(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] key,
                            logic [VAL_W-1:0] val);
    int gap;
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.key     <= key;
    req_ch.value   <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(cmd, key, val);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 99) < 25) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 5);
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom();
  endfunction

  task automatic random_item();
    int                      sel;
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      drive_item(CMD_W'($urandom_range(0, 3)), KEY_W'($urandom()), $urandom());
    end else begin
      key = key_base + KEY_W'($urandom_range(0, 23));
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        key_base = KEY_W'($urandom_range(1, 32767 - 23));
        drive_item(CMD_CLEAR, KEY_W'($urandom()), $urandom());
      end else if (sel < 45) begin
        drive_item(CMD_ADD, key, pick_value());
      end else if (sel < 68) begin
        drive_item(CMD_REMOVE, key, $urandom());
      end else if (sel < 96) begin
        if ($urandom_range(0, 19) == 0) key = '0;
        drive_item(CMD_FIND, key, $urandom());
      end else begin
        key = KEY_W'(-$signed($urandom_range(0, 32768)));
        cmd = $urandom_range(0, 1) ? CMD_ADD : CMD_REMOVE;
        drive_item(cmd, key, $urandom());
      end
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[small_key_value_table] ERROR");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_CLEAR;
    req_ch.key     <= '0;
    req_ch.value   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, invalid keys, extremes
    drive_item(CMD_FIND, 16'sd0, 32'h1234_5678);
    drive_item(CMD_FIND, -16'sd32768, '1);
    drive_item(CMD_ADD, 16'sd0, 32'hdead_beef);
    drive_item(CMD_ADD, -16'sd32768, '1);
    drive_item(CMD_REMOVE, -16'sd1, '0);
    drive_item(CMD_REMOVE, 16'sd0, '0);
    drive_item(CMD_ADD, 16'sd32767, 32'hffff_ffff);
    drive_item(CMD_ADD, 16'sd1, 32'h0);
    drive_item(CMD_ADD, 16'sd32767, 32'h5555_aaaa);
    drive_item(CMD_FIND, 16'sd32767, '0);
    // freed slot then a duplicate that lands in the hole
    drive_item(CMD_REMOVE, 16'sd1, '0);
    drive_item(CMD_REMOVE, 16'sd1, '0);
    drive_item(CMD_ADD, 16'sd2, 32'h0000_0002);
    drive_item(CMD_REMOVE, 16'sd32767, '0);
    drive_item(CMD_ADD, 16'sd2, 32'haaaa_5555);
    drive_item(CMD_FIND, 16'sd2, '0);
    drive_item(CMD_FIND, 16'sd0, '0);
    drive_item(CMD_CLEAR, '1, '1);
    // full table
    for (int i = 0; i < SLOTS; i++)
      drive_item(CMD_ADD, KEY_W'(16'sh4000 + i), $urandom());
    drive_item(CMD_ADD, 16'sh7000, 32'h0bad_0bad);
    drive_item(CMD_FIND, 16'sd0, '0);
    drive_item(CMD_FIND, KEY_W'(16'sh4000 + SLOTS - 1), '0);

    for (int n = 0; n < RANDOM_ITEMS; n++)
      random_item();

    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d responses: clear %0d, add %0d, remove %0d, find %0d",
             sb.checked_count, sb.cmd_seen[CMD_CLEAR], sb.cmd_seen[CMD_ADD],
             sb.cmd_seen[CMD_REMOVE], sb.cmd_seen[CMD_FIND]);
    $display("status mix: ok %0d, invalid %0d, exists %0d, no space %0d, not found %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_INVALID],
             sb.status_seen[ST_EXISTS], sb.status_seen[ST_NO_SPACE],
             sb.status_seen[ST_NOT_FOUND]);
    if (sb.error_count == 0) begin
      $display("[small_key_value_table] OK");
    end else begin
      $display("[small_key_value_table] ERROR");
    end
    $finish;
  end
endmodule
